// File: design/rle_pkg.sv
// Shared types and constants of the byte run-length decompressor.
`timescale 1ns / 1ps
`default_nettype none

package rle_pkg;

    localparam logic [7:0] FLAG_REPEAT_BIT = 8'h80;
    localparam logic [7:0] FLAG_COUNT_MASK = 8'h7F;
    localparam logic [7:0] REPEAT_BIAS     = 8'd3;
    localparam logic [7:0] LITERAL_BIAS    = 8'd1;
    localparam logic [1:0] HDR_LAST_INDEX  = 2'd3;
    localparam logic [2:0] WORD_BYTES      = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FLAG,
        PH_REPEAT,
        PH_LITERAL,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_BYTES,
        CMD_FLUSH
    } cmd_kind_t;

    // One unit of work for the back end.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] value;
        logic [7:0] count;
        logic       last;
        logic       overflow;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// File: design/rle_byte_decompressor.sv
// Top level of the byte run-length decompressor: parser, command queue, word packer.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// s_       | in        | s_valid / s_ready  | s_in_byte[7:0], s_start_of_stream
// m_       | out       | m_valid / m_ready  | m_data_word[31:0], m_byte_count[2:0],
//          |           |                    | m_last, m_overflow
//
// The parser takes one item per cycle while the command queue has room.
// Literal bytes leave the packer at one byte per cycle, and a repeat run fills up
// to four lanes of a word per cycle, while the result register can take each word.
// Reset (aresetn low, synchronous) clears all control state; no clearing pass.
// A stalled m_ready holds the result register, then the packer, then the queue fills
// and s_ready drops.

module rle_byte_decompressor
    import rle_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_start_of_stream,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_data_word,
    output logic [2:0]       m_byte_count,
    output logic             m_last,
    output logic             m_overflow
);

    logic    accept;
    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    cmd_t    head;
    q_stat_t stat;

    // Take an item only when its command is sure of a slot.
    assign s_ready = !stat.full;
    assign accept  = s_valid && s_ready;

    rle_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .in_byte         (s_in_byte),
        .start_of_stream (s_start_of_stream),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    rle_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    rle_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .stat         (stat),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data_word  (m_data_word),
        .m_byte_count (m_byte_count),
        .m_last       (m_last),
        .m_overflow   (m_overflow)
    );

    // An overflow always ends the stream.
    a_ovf_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_last)
        else $error("overflow result without last");

    // Every word before the final one of a stream is full.
    a_full_words: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_byte_count == WORD_BYTES)
        else $error("partial word before end of stream");

    // Nothing is pushed into a full queue.
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.full |-> !push)
        else $error("command pushed into full queue");

endmodule

`default_nettype wire

// File: design/rle_front.sv
// Front end: parses the header and flag bytes and issues commands to the queue.
`timescale 1ns / 1ps
`default_nettype none

module rle_front
    import rle_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       start_of_stream,
    output logic            push,
    output cmd_t            push_cmd
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  hdr_idx_reg, hdr_idx_next;
    logic [23:0] size_reg, size_next;
    logic [23:0] prod_reg, prod_next;
    logic [7:0]  lit_rem_reg, lit_rem_next;
    logic [7:0]  rep_len_reg, rep_len_next;

    logic [7:0]  width;
    logic [24:0] need;
    logic [23:0] prod_rep;
    logic [23:0] prod_lit;
    logic [7:0]  lit_dec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DONE;
            hdr_idx_reg <= 2'd0;
            size_reg    <= 24'd0;
            prod_reg    <= 24'd0;
            lit_rem_reg <= 8'd0;
            rep_len_reg <= 8'd0;
        end else begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            size_reg    <= size_next;
            prod_reg    <= prod_next;
            lit_rem_reg <= lit_rem_next;
            rep_len_reg <= rep_len_next;
        end
    end

    assign width    = (in_byte & FLAG_COUNT_MASK)
                      + (((in_byte & FLAG_REPEAT_BIT) != 8'd0) ? REPEAT_BIAS : LITERAL_BIAS);
    assign need     = {1'b0, prod_reg} + {17'd0, width};
    assign prod_rep = prod_reg + {16'd0, rep_len_reg};
    assign prod_lit = prod_reg + 24'd1;
    assign lit_dec  = (lit_rem_reg != 8'd0) ? lit_rem_reg - 8'd1 : 8'd0;

    always_comb begin
        phase_next        = phase_reg;
        hdr_idx_next      = hdr_idx_reg;
        size_next         = size_reg;
        prod_next         = prod_reg;
        lit_rem_next      = lit_rem_reg;
        rep_len_next      = rep_len_reg;
        push              = 1'b0;
        push_cmd.kind     = CMD_BYTES;
        push_cmd.value    = in_byte;
        push_cmd.count    = 8'd0;
        push_cmd.last     = 1'b0;
        push_cmd.overflow = 1'b0;
        if (accept) begin
            if (start_of_stream) begin
                phase_next    = PH_HEADER;
                hdr_idx_next  = 2'd1;
                size_next     = 24'd0;
                prod_next     = 24'd0;
                lit_rem_next  = 8'd0;
                rep_len_next  = 8'd0;
                push          = 1'b1;
                push_cmd.kind = CMD_START;
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        case (hdr_idx_reg)
                            2'd1: size_next[7:0]  = in_byte;
                            2'd2: size_next[15:8] = in_byte;
                            default: size_next[23:16] = in_byte;
                        endcase
                        if (hdr_idx_reg == HDR_LAST_INDEX) begin
                            hdr_idx_next = 2'd0;
                            phase_next   = PH_FLAG;
                            if ({in_byte, size_reg[15:0]} == 24'd0) begin
                                // Empty stream: one empty final result.
                                push          = 1'b1;
                                push_cmd.kind = CMD_FLUSH;
                                push_cmd.last = 1'b1;
                                phase_next    = PH_DONE;
                            end
                        end else begin
                            hdr_idx_next = hdr_idx_reg + 2'd1;
                        end
                    end
                    PH_FLAG: begin
                        if (need > {1'b0, size_reg}) begin
                            push              = 1'b1;
                            push_cmd.kind     = CMD_FLUSH;
                            push_cmd.last     = 1'b1;
                            push_cmd.overflow = 1'b1;
                            phase_next        = PH_DONE;
                        end else if ((in_byte & FLAG_REPEAT_BIT) != 8'd0) begin
                            rep_len_next = width;
                            phase_next   = PH_REPEAT;
                        end else begin
                            lit_rem_next = width;
                            phase_next   = PH_LITERAL;
                        end
                    end
                    PH_REPEAT: begin
                        push           = 1'b1;
                        push_cmd.count = rep_len_reg;
                        push_cmd.last  = (prod_rep == size_reg);
                        prod_next      = prod_rep;
                        rep_len_next   = 8'd0;
                        phase_next     = (prod_rep == size_reg) ? PH_DONE : PH_FLAG;
                    end
                    PH_LITERAL: begin
                        push           = 1'b1;
                        push_cmd.count = 8'd1;
                        push_cmd.last  = (prod_lit == size_reg);
                        prod_next      = prod_lit;
                        lit_rem_next   = lit_dec;
                        if (prod_lit == size_reg) begin
                            phase_next = PH_DONE;
                        end else if (lit_dec == 8'd0) begin
                            phase_next = PH_FLAG;
                        end
                    end
                    default: begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: design/rle_cmd_fifo.sv
// Short command queue between the parser and the word packer.
`timescale 1ns / 1ps
`default_nettype none

module rle_cmd_fifo
    import rle_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  cmd_t      push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output q_stat_t   stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: design/rle_back.sv
// Back end: packs command bytes into words and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module rle_back
    import rle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  cmd_t             head,
    input  q_stat_t          stat,
    output logic             pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_data_word,
    output logic [2:0]       m_byte_count,
    output logic             m_last,
    output logic             m_overflow
);

    logic [23:0] acc_reg, acc_next;
    logic [1:0]  pend_reg, pend_next;
    logic [7:0]  done_reg, done_next;
    logic        m_valid_reg;
    logic [31:0] m_data_word_reg;
    logic [2:0]  m_byte_count_reg;
    logic        m_last_reg;
    logic        m_overflow_reg;

    logic        out_free;
    logic [31:0] acc_ext;
    logic [7:0]  rem;
    logic [2:0]  space;
    logic [2:0]  take;
    logic [2:0]  new_cnt;
    logic        final_step;
    logic [31:0] packed_word;
    logic        emit;
    logic        load;
    logic [31:0] emit_word;
    logic [2:0]  emit_cnt;
    logic        emit_last;
    logic        emit_ovf;

    assign out_free   = !m_valid_reg || m_ready;
    assign acc_ext    = {8'd0, acc_reg};
    assign rem        = head.count - done_reg;
    assign space      = WORD_BYTES - {1'b0, pend_reg};
    assign take       = (rem < {5'd0, space}) ? rem[2:0] : space;
    assign new_cnt    = {1'b0, pend_reg} + take;
    assign final_step = ({5'd0, take} == rem);

    // Keep pending bytes, fill the next lanes with the value, zero the rest.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < {1'b0, pend_reg}) begin
                packed_word[8*i +: 8] = acc_ext[8*i +: 8];
            end else if (3'(i) < new_cnt) begin
                packed_word[8*i +: 8] = head.value;
            end else begin
                packed_word[8*i +: 8] = 8'd0;
            end
        end
    end

    always_comb begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        done_next = done_reg;
        pop       = 1'b0;
        emit      = 1'b0;
        emit_word = acc_ext;
        emit_cnt  = {1'b0, pend_reg};
        emit_last = 1'b1;
        emit_ovf  = head.overflow;
        if (!stat.empty) begin
            case (head.kind)
                CMD_START: begin
                    // Drop the partial word of the abandoned stream.
                    acc_next  = 24'd0;
                    pend_next = 2'd0;
                    done_next = 8'd0;
                    pop       = 1'b1;
                end
                CMD_FLUSH: begin
                    emit = 1'b1;
                    if (out_free) begin
                        acc_next  = 24'd0;
                        pend_next = 2'd0;
                        done_next = 8'd0;
                        pop       = 1'b1;
                    end
                end
                CMD_BYTES: begin
                    emit      = (new_cnt == WORD_BYTES) || (final_step && head.last);
                    emit_word = packed_word;
                    emit_cnt  = new_cnt;
                    emit_last = final_step && head.last;
                    emit_ovf  = 1'b0;
                    if (!emit || out_free) begin
                        if (emit) begin
                            acc_next  = 24'd0;
                            pend_next = 2'd0;
                        end else begin
                            acc_next  = packed_word[23:0];
                            pend_next = new_cnt[1:0];
                        end
                        if (final_step) begin
                            done_next = 8'd0;
                            pop       = 1'b1;
                        end else begin
                            done_next = done_reg + {5'd0, take};
                        end
                    end
                end
                default: begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    assign load = emit && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= 24'd0;
            pend_reg    <= 2'd0;
            done_reg    <= 8'd0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            done_reg <= done_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_word_reg  <= emit_word;
            m_byte_count_reg <= emit_cnt;
            m_last_reg       <= emit_last;
            m_overflow_reg   <= emit_ovf;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data_word  = m_data_word_reg;
    assign m_byte_count = m_byte_count_reg;
    assign m_last       = m_last_reg;
    assign m_overflow   = m_overflow_reg;

endmodule

`default_nettype wire

// File: dv/tb_rle_byte_decompressor.sv
// Self-checking testbench of the byte run-length decompressor, with a word scoreboard.
`timescale 1ns / 1ps

module tb_rle_byte_decompressor;
    import rle_pkg::*;

    // Generous cap on the run: every item may cause a full repeat run of words, each
    // waiting out the longest receiver stall, taken a few times over.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_ITEMS = 480;
    // Cycles to watch the output after the last expected word, for stray results.
    localparam int DRAIN_CYCLES = 60;
    // Cap on mismatch reports, so that a broken block cannot flood the log.
    localparam int REPORT_CAP = 200;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  count;
        logic        last;
        logic        overflow;
    } rle_word_t;

    typedef struct {
        logic [7:0] data;
        logic       sos;
        int         gap;
    } rle_item_t;

    // Scoreboard: unpacks each accepted byte into the words it must produce, and
    // compares every word leaving the block with the oldest one waiting.
    class rle_scoreboard;
        phase_t      phase;
        logic [1:0]  hdr_idx;
        logic [23:0] out_size;
        logic [23:0] produced;
        logic [7:0]  lit_left;
        logic [7:0]  rep_len;
        logic [23:0] acc;
        logic [1:0]  acc_cnt;
        bit          idle;
        int          errors;
        rle_word_t   expected_words[$];

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            phase    = PH_HEADER;
            hdr_idx  = '0;
            out_size = '0;
            produced = '0;
            lit_left = '0;
            rep_len  = '0;
            acc      = '0;
            acc_cnt  = '0;
            idle     = 1'b1;
        endfunction

        function void finish_stream();
            idle    = 1'b1;
            phase   = PH_DONE;
            acc     = '0;
            acc_cnt = '0;
        endfunction

        // Append one word to the tail of the expected list.
        function void expect_word(logic [31:0] word, logic [2:0] count, logic last,
                                  logic overflow);
            rle_word_t w;
            w = '{word, count, last, overflow};
            expected_words.insert(expected_words.size(), w);
        endfunction

        // Append one output byte; close the word when full or when the size is met.
        function void push_out(logic [7:0] b);
            logic [31:0] word;
            logic [2:0]  cnt;
            bit          at_end;
            word     = {8'h00, acc} | (32'(b) << (8 * int'(acc_cnt)));
            cnt      = 3'(acc_cnt) + 3'd1;
            produced = produced + 24'd1;
            at_end   = (produced == out_size);
            if (cnt == WORD_BYTES || at_end) begin
                expect_word(word, cnt, at_end, 1'b0);
                acc     = '0;
                acc_cnt = '0;
                if (at_end) begin
                    finish_stream();
                end
            end else begin
                acc     = word[23:0];
                acc_cnt = cnt[1:0];
            end
        endfunction

        function void note_byte(logic [7:0] b, logic sos);
            int width;
            int i;
            if (sos) begin
                clear_state();
                idle    = 1'b0;
                hdr_idx = 2'd1;
                return;
            end
            if (idle) begin
                return;
            end
            case (phase)
                PH_HEADER: begin
                    out_size = out_size | (24'(b) << (8 * (int'(hdr_idx) - 1)));
                    if (hdr_idx == HDR_LAST_INDEX) begin
                        hdr_idx = '0;
                        phase   = PH_FLAG;
                        if (out_size == '0) begin
                            expect_word(32'h0, 3'd0, 1'b1, 1'b0);
                            finish_stream();
                        end
                    end else begin
                        hdr_idx = hdr_idx + 2'd1;
                    end
                end
                PH_FLAG: begin
                    if ((b & FLAG_REPEAT_BIT) != 8'h00) begin
                        width = int'(b & FLAG_COUNT_MASK) + int'(REPEAT_BIAS);
                    end else begin
                        width = int'(b & FLAG_COUNT_MASK) + int'(LITERAL_BIAS);
                    end
                    if (int'(produced) + width > int'(out_size)) begin
                        expect_word({8'h00, acc}, 3'(acc_cnt), 1'b1, 1'b1);
                        finish_stream();
                    end else if ((b & FLAG_REPEAT_BIT) != 8'h00) begin
                        rep_len = 8'(width);
                        phase   = PH_REPEAT;
                    end else begin
                        lit_left = 8'(width);
                        phase    = PH_LITERAL;
                    end
                end
                PH_REPEAT: begin
                    phase = PH_FLAG;
                    for (i = 0; i < int'(rep_len) && !idle; i++) begin
                        push_out(b);
                    end
                    rep_len = '0;
                end
                PH_LITERAL: begin
                    if (lit_left > 8'd0) begin
                        lit_left = lit_left - 8'd1;
                    end
                    if (lit_left == 8'd0) begin
                        phase = PH_FLAG;
                    end
                    push_out(b);
                end
                default: begin
                    finish_stream();
                end
            endcase
        endfunction

        function void check_word(logic [31:0] word, logic [2:0] count, logic last,
                                 logic overflow);
            rle_word_t exp_w;
            bit        bad;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t: unexpected word, expected none, got %h count %0d last %b ovf %b",
                             $time, word, count, last, overflow);
                end
                return;
            end
            exp_w = expected_words.pop_front();
            bad   = (word !== exp_w.word) || (count !== exp_w.count) ||
                    (last !== exp_w.last) || (overflow !== exp_w.overflow);
            if (bad) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t: word mismatch, expected %h count %0d last %b ovf %b, got %h count %0d last %b ovf %b",
                             $time, exp_w.word, exp_w.count, exp_w.last, exp_w.overflow,
                             word, count, last, overflow);
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_start_of_stream;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_data_word;
    logic [2:0]  m_byte_count;
    logic        m_last;
    logic        m_overflow;

    rle_scoreboard sb;
    rle_item_t     stim_q[$];
    int            cycles = 0;

    rle_byte_decompressor i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .s_start_of_stream (s_start_of_stream),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data_word       (m_data_word),
        .m_byte_count      (m_byte_count),
        .m_last            (m_last),
        .m_overflow        (m_overflow)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Idle gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Queue one input item; burst streams are sent back to back with no gaps.
    task automatic add_item(logic [7:0] data, logic sos, bit burst);
        rle_item_t new_it;
        new_it = '{data, sos, burst ? 0 : pick_gap()};
        stim_q.insert(stim_q.size(), new_it);
    endtask

    // Build one random stream: mostly well-formed with random content, sometimes
    // cut short by the next start, run past its size, or pure noise.
    task automatic make_stream(output int counted);
        int  kind;
        int  size;
        int  left;
        int  cnt;
        int  width;
        int  cut;
        int  n0;
        int  i;
        bit  burst;
        bit  big;
        burst = ($urandom_range(0, 3) == 0);
        kind  = $urandom_range(0, 99);
        n0    = stim_q.size();
        if (kind < 10) begin
            // Noise: a start with a random header and random bytes after it.
            add_item(8'($urandom), 1'b1, burst);
            repeat ($urandom_range(3, 20)) begin
                add_item(8'($urandom), ($urandom_range(0, 19) == 0), burst);
            end
        end else begin
            cnt = $urandom_range(0, 99);
            if (cnt < 10) begin
                size = $urandom_range(0, 4);
            end else if (cnt < 70) begin
                size = $urandom_range(5, 24);
            end else if (cnt < 95) begin
                size = $urandom_range(25, 80);
            end else begin
                size = $urandom_range(150, 400);
            end
            big = (size > 100);
            add_item(8'($urandom), 1'b1, burst);
            add_item(size[7:0], 1'b0, burst);
            add_item(size[15:8], 1'b0, burst);
            add_item(size[23:16], 1'b0, burst);
            left = size;
            while (left > 0) begin
                if (left < 130 && $urandom_range(0, 19) == 0) begin
                    // Run past the size: the stream ends on this flag.
                    if (left < 128 && $urandom_range(0, 1) == 0) begin
                        width = $urandom_range(left + 1, 128);
                        add_item(8'(width - 1), 1'b0, burst);
                    end else begin
                        width = $urandom_range((left + 1 > 3) ? left + 1 : 3, 130);
                        add_item(FLAG_REPEAT_BIT | 8'(width - 3), 1'b0, burst);
                        add_item(8'($urandom), 1'b0, burst);
                    end
                    left = 0;
                end else if (left >= 3 && $urandom_range(0, 99) < (big ? 80 : 40)) begin
                    cnt = $urandom_range(3, (left < 130) ? left : 130);
                    add_item(FLAG_REPEAT_BIT | 8'(cnt - 3), 1'b0, burst);
                    add_item(8'($urandom), 1'b0, burst);
                    left -= cnt;
                end else begin
                    cnt = $urandom_range(1, (left < 128) ? left : 128);
                    add_item(8'(cnt - 1), 1'b0, burst);
                    for (i = 0; i < cnt; i++) begin
                        add_item(8'($urandom), 1'b0, burst);
                    end
                    left -= cnt;
                end
            end
            if (kind < 20 && stim_q.size() - n0 > 2) begin
                // Broken stream: drop the tail so that the next start cuts in.
                cut = $urandom_range(1, stim_q.size() - n0 - 1);
                while (stim_q.size() > n0 + cut) begin
                    void'(stim_q.pop_back());
                end
            end
        end
        counted = stim_q.size() - n0;
        if ($urandom_range(0, 99) < 15) begin
            // Trailing bytes after the end: ignored by the block.
            repeat ($urandom_range(1, 4)) begin
                add_item(8'($urandom), 1'b0, burst);
            end
        end
    endtask

    // Directed opening: idle input, zero size, both run kinds, an exact fit,
    // a run past the size with bytes pending, and a start mid-stream.
    task automatic make_directed();
        // Bytes before any start are ignored.
        add_item(8'hFF, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        // Zero size: one empty last word on the fourth header byte.
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        // Size five: literal of one, repeat of three, literal of one.
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'h05, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b0);
        add_item(FLAG_REPEAT_BIT, 1'b0, 1'b0);
        add_item(8'hA5, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'h5A, 1'b0, 1'b0);
        // Size six: two literal bytes, then the longest repeat overflows with two pending.
        add_item(8'h3C, 1'b1, 1'b1);
        add_item(8'h06, 1'b0, 1'b1);
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'h01, 1'b0, 1'b1);
        add_item(8'h12, 1'b0, 1'b1);
        add_item(8'h34, 1'b0, 1'b1);
        add_item(8'hFF, 1'b0, 1'b1);
        add_item(8'h77, 1'b0, 1'b1);
        // Largest size, longest literal, then a new start drops it mid-run.
        add_item(8'hC3, 1'b1, 1'b0);
        add_item(8'hFF, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b0);
        add_item(FLAG_COUNT_MASK, 1'b0, 1'b0);
        add_item(8'h01, 1'b0, 1'b0);
        add_item(8'h02, 1'b0, 1'b0);
    endtask

    // Timeout watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result monitor: check each word taken by the receiver.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word(m_data_word, m_byte_count, m_last, m_overflow);
        end
    end

    // Receiver: random ready with stretches of no stalls, plus one long hold-off
    // while the sender keeps offering items, to fill the block and stall its input.
    initial begin
        int seg_left;
        int rx_cycles;
        int g;
        bit rdy;
        bit pressure_done;
        seg_left      = 0;
        rx_cycles     = 0;
        rdy           = 1'b0;
        pressure_done = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            rx_cycles++;
            if (seg_left > 0) begin
                seg_left--;
            end else if (!pressure_done && rx_cycles >= 700) begin
                pressure_done = 1'b1;
                rdy           = 1'b0;
                seg_left      = 400;
            end else if (rdy) begin
                g = pick_gap();
                if (g > 0) begin
                    rdy      = 1'b0;
                    seg_left = g - 1;
                end else begin
                    seg_left = $urandom_range(0, 20);
                end
            end else begin
                rdy      = 1'b1;
                seg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(0, 20);
            end
            m_ready <= rdy;
        end
    end

    // Main flow: build the stimulus, reset, drive every item, drain, report.
    initial begin
        rle_item_t it;
        int        total;
        int        n;
        sb = new();
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_in_byte         <= '0;
        s_start_of_stream <= 1'b0;

        make_directed();
        total = 0;
        while (total < RANDOM_ITEMS) begin
            make_stream(n);
            total += n;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() > 0) begin
            it = stim_q.pop_front();
            if (it.gap > 0) begin
                s_valid <= 1'b0;
                repeat (it.gap) @(posedge aclk);
            end
            s_valid           <= 1'b1;
            s_in_byte         <= it.data;
            s_start_of_stream <= it.sos;
            // Hold the item until the block takes it.
            do begin
                @(posedge aclk);
            end while (!s_ready);
            sb.note_byte(it.data, it.sos);
        end
        s_valid <= 1'b0;

        // Wait for every expected word, then watch a little longer for strays.
        while (sb.pending() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
design/rle_pkg.sv
design/rle_front.sv
design/rle_cmd_fifo.sv
design/rle_back.sv
design/rle_byte_decompressor.sv
dv/tb_rle_byte_decompressor.sv
